// ----- hw/rtl/sorl_pkg.sv -----
// shared constants and codes for the grid relaxation block
`default_nettype none
package sorl_pkg;
	localparam int ROWS   = 128;
	localparam int COLS   = 1024;
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int VAL_W  = 32;
	localparam int SUM_W  = VAL_W + 2;
	localparam int WGT_W  = 15;
	localparam int ENT_W  = VAL_W + 1;
	localparam logic [WGT_W-1:0] WGT_RESET = 15'd20480;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_SWEEP = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             fixed;
	} cell_t;
endpackage
`default_nettype wire

// ----- hw/rtl/sorl_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module sorl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/sorl_cell_update.sv -----
// three-stage pipeline computing one relaxed cell value
`default_nettype none
module sorl_cell_update (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [sorl_pkg::VAL_W-1:0]  v,
	input  wire logic signed [sorl_pkg::SUM_W-1:0]  s,
	input  wire logic        [sorl_pkg::WGT_W-1:0]  w,
	output logic                                    done,
	output logic        [sorl_pkg::VAL_W-1:0]       res
);
	import sorl_pkg::*;

	logic               vld_s1, vld_s2;
	logic signed [34:0] d_s1;
	logic signed [VAL_W-1:0] v_s1, v_s2;
	logic [WGT_W-1:0]   w_s1;
	logic signed [50:0] p_s2;
	logic signed [50:0] t;
	logic signed [34:0] step;
	logic signed [36:0] sum;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

	// rounding of the step and its sum with the cell value
	always_comb begin
		t    = p_s2 + 51'sd32768;
		step = 35'(t >>> 16);
		sum  = 37'(v_s2) + 37'(step);
	end

	// difference, product, result
	always_ff @(posedge clk) begin
		d_s1 <= 35'(s) - (35'(v) <<< 2);
		v_s1 <= v;
		w_s1 <= w;
		p_s2 <= 51'(d_s1) * 51'($signed({1'b0, w_s1}));
		v_s2 <= v_s1;
		if (sum > 37'sd2147483647) begin
			res <= 32'h7fff_ffff;
		end else if (sum < -37'sd2147483648) begin
			res <= 32'h8000_0000;
		end else begin
			res <= sum[31:0];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/sor_laplace_grid_relaxation.sv -----
// Load items pass through ST_DONE to the result; read items pass through ST_RD and then ST_DONE.
// A sweep item updates every cell in turn: every cell needs five
// reads on the single grid read port, a start of the update in ST_SW_LAST and the arithmetic of sorl_cell_update.
// Items are handled one at a time; a finished result waits in the output register.
// After reset a clearing pass writes ROWS*COLS zero cells, one a cycle, before
// the first item is accepted; configuration writes are taken throughout.
`default_nettype none
module sor_laplace_grid_relaxation (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [sorl_pkg::WGT_W-1:0] cfg_data,   // relax_weight
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// row[6:0], col[16:7], load_value[48:17], load_fixed[49]
	input  wire logic [55:0]                s_tdata,
	input  wire logic [1:0]                 s_tuser,    // action
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic      [31:0]                m_tdata,    // read_value
	output logic      [1:0]                 m_tuser     // ack_kind
);
	import sorl_pkg::*;

	localparam logic [2:0] ST_CLR     = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_RD      = 3'd2;
	localparam logic [2:0] ST_SW_RD   = 3'd3;
	localparam logic [2:0] ST_SW_LAST = 3'd4;
	localparam logic [2:0] ST_SW_CALC = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [WGT_W-1:0]  wgt_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [2:0]        ph_q;
	logic signed [VAL_W-1:0] v_q;
	logic              fix_q;
	logic signed [SUM_W-1:0] s_q;
	logic [VAL_W-1:0]  res_q;
	logic [1:0]        kind_q;
	logic              inside_q;

	logic [6:0]        in_row;
	logic [9:0]        in_col;
	logic [VAL_W-1:0]  in_val;
	logic              in_fix;
	logic              in_inside;
	logic [ADDR_W-1:0] in_addr;
	logic              accept;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	cell_t             wr_data;
	logic [ADDR_W-1:0] rd_addr;
	cell_t             rd_data;
	logic [ROW_W-1:0]  rr;
	logic [COL_W-1:0]  cc;
	logic signed [SUM_W-1:0] rd_ext;
	logic signed [SUM_W-1:0] s_in;
	logic              fu_done;
	logic [VAL_W-1:0]  fu_res;
	logic              last_col, last_row;

	// input unpacking
	assign in_row    = s_tdata[6:0];
	assign in_col    = s_tdata[16:7];
	assign in_val    = s_tdata[48:17];
	assign in_fix    = s_tdata[49];
	assign in_inside = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
	assign in_addr   = ADDR_W'(32'(in_row) * COLS + 32'(in_col));
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign last_col = (col_q == COL_W'(COLS - 1));
	assign last_row = (row_q == ROW_W'(ROWS - 1));
	assign rd_ext   = SUM_W'($signed(rd_data.value));
	assign s_in     = s_q + rd_ext;

	// neighbor selection with mirrored edges
	always_comb begin
		rr = row_q;
		cc = col_q;
		case (ph_q)
			3'd1: rr = (row_q == '0) ? ROW_W'(1) : row_q - ROW_W'(1);
			3'd2: rr = last_row ? row_q - ROW_W'(1) : row_q + ROW_W'(1);
			3'd3: cc = (col_q == '0) ? COL_W'(1) : col_q - COL_W'(1);
			3'd4: cc = last_col ? col_q - COL_W'(1) : col_q + COL_W'(1);
			default: ;
		endcase
		if (state_q == ST_IDLE) begin
			rd_addr = in_addr;
		end else begin
			rd_addr = ADDR_W'(32'(rr) * COLS + 32'(cc));
		end
	end

	// grid write port
	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = ADDR_W'(32'(row_q) * COLS + 32'(col_q));
		wr_data.value = fu_res;
		wr_data.fixed = 1'b0;
		case (state_q)
			ST_CLR: begin
				wr_en         = 1'b1;
				wr_addr       = clr_q;
				wr_data.value = '0;
			end
			ST_IDLE: begin
				wr_en         = accept && (s_tuser == ACT_LOAD) && in_inside;
				wr_addr       = in_addr;
				wr_data.value = in_val;
				wr_data.fixed = in_fix;
			end
			ST_SW_CALC: begin
				wr_en = fu_done && !fix_q;
			end
			default: ;
		endcase
	end

	sorl_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_grid (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sorl_cell_update u_upd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SW_LAST),
		.v      (v_q),
		.s      (s_in),
		.w      (wgt_q),
		.done   (fu_done),
		.res    (fu_res)
	);

	// weight register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wgt_q <= WGT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			wgt_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ph_q     <= '0;
			v_q      <= '0;
			fix_q    <= 1'b0;
			s_q      <= '0;
			res_q    <= '0;
			kind_q   <= '0;
			inside_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q   <= s_tuser;
						inside_q <= in_inside;
						res_q    <= '0;
						row_q    <= '0;
						col_q    <= '0;
						ph_q     <= '0;
						if (s_tuser == ACT_READ) begin
							state_q <= ST_RD;
						end else if (s_tuser == ACT_SWEEP) begin
							state_q <= ST_SW_RD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RD: begin
					res_q   <= inside_q ? rd_data.value : '0;
					state_q <= ST_DONE;
				end
				ST_SW_RD: begin
					// accumulate data of the previous read
					case (ph_q)
						3'd1: begin
							v_q   <= rd_data.value;
							fix_q <= rd_data.fixed;
						end
						3'd2: s_q <= rd_ext;
						3'd3, 3'd4: s_q <= s_in;
						default: ;
					endcase
					if (ph_q == 3'd4) begin
						state_q <= ST_SW_LAST;
					end
					ph_q <= ph_q + 3'd1;
				end
				ST_SW_LAST: begin
					ph_q    <= '0;
					state_q <= ST_SW_CALC;
				end
				ST_SW_CALC: begin
					if (fu_done) begin
						if (last_col) begin
							col_q <= '0;
							if (last_row) begin
								state_q <= ST_DONE;
							end else begin
								row_q   <= row_q + ROW_W'(1);
								state_q <= ST_SW_RD;
							end
						end else begin
							col_q   <= col_q + COL_W'(1);
							state_q <= ST_SW_RD;
						end
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= res_q;
						m_tuser  <= kind_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_fu_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		fu_done |-> state_q == ST_SW_CALC) else $error("update result outside calc");
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !s_tready) else $error("item accepted during clear");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_RD |-> ph_q <= 3'd4) else $error("read phase out of range");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> 32'(wr_addr) < CELLS) else $error("grid write out of range");
	a_last_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SW_LAST |=> state_q == ST_SW_CALC) else $error("sweep sequence broken");
endmodule
`default_nettype wire
